FILE: design/bbc_pkg.sv
package bbc_pkg;

    localparam int unsigned CNT_W = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_MOD,
        S_RESP
    } t_state;

    // One buffer entry as it sits in the tag memory.
    typedef struct packed {
        logic [7:0]       dev;
        logic [31:0]      blk;
        logic [CNT_W-1:0] cnt;
        logic [31:0]      stamp;
        logic             filled;
    } t_entry;

endpackage

FILE: design/bbc_req_if.sv
interface bbc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  entry_index;
    logic [31:0] now;

    modport source (output valid, op, device, block_number, entry_index, now, input ready);
    modport sink (input valid, op, device, block_number, entry_index, now, output ready);
endinterface

FILE: design/bbc_rsp_if.sv
interface bbc_rsp_if;
    logic       valid;
    logic       ready;
    logic [4:0] entry;
    logic       needs_fill;
    logic [1:0] status;

    modport source (output valid, entry, needs_fill, status, input ready);
    modport sink (input valid, entry, needs_fill, status, output ready);
endinterface

FILE: design/block_buffer_cache_lru_top.sv
// Channel  Dir  Word fields                                   Handshake
// i_req    in   op, device, block_number, entry_index, now    valid/ready
// o_rsp    out  entry, needs_fill, status                     valid/ready
//
// Get: one tag-memory read per cycle sweeps all ENTRIES for a tag match and the oldest
//   free entry in the same pass; drain and decide follow before the word loads the output.
// Release, pin, unpin: one read and one write-back (none out of range); word loads from modify.
// One word in flight; the single read port of the tag memory sets the get time.
// Reset clears per-entry valid flags, so every entry reads as zero at once; no clearing pass.
// A stalled output holds the finished word while the next request is already taken.
module block_buffer_cache_lru_top #(
    parameter int unsigned ENTRIES = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bbc_req_if.sink   i_req,
    bbc_rsp_if.source o_rsp
);
    import bbc_pkg::*;

    localparam int unsigned IW = $clog2(ENTRIES);

    // tag memory and its per-entry valid flags
    t_entry               r_mem [ENTRIES];
    logic [ENTRIES-1:0]   r_ent_vld;
    t_entry               r_rd_word;
    logic                 r_rd_vld;
    t_entry               w_rd_word;
    logic [IW-1:0]        w_rd_addr;
    logic                 w_wr_en;
    t_entry               w_wr_word;

    t_state        r_state, n_state;
    t_op           r_op, n_op;
    logic [7:0]    r_dev, n_dev;
    logic [31:0]   r_blk, n_blk;
    logic [31:0]   r_now, n_now;
    logic [IW-1:0] r_pick, n_pick;
    logic [IW-1:0] r_addr, n_addr;

    // scan pipeline: compare stage works on the read word in the cycle after the read
    logic          r_cmp_vld, n_cmp_vld;
    logic [IW-1:0] r_cmp_idx, n_cmp_idx;
    logic          r_hit, n_hit;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    logic          r_free, n_free;
    logic [IW-1:0] r_lru_idx, n_lru_idx;
    logic [31:0]   r_lru_time, n_lru_time;

    // pending result for words that skip the write-back
    logic [4:0]    r_res_entry, n_res_entry;
    t_status       r_res_status, n_res_status;

    // output register
    logic          r_out_vld, n_out_vld;
    logic [4:0]    r_out_entry, n_out_entry;
    logic          r_out_fill, n_out_fill;
    t_status       r_out_status, n_out_status;

    logic          w_slot_free;
    t_status       w_mod_status;
    logic          w_mod_fill;

    assign w_rd_word   = r_rd_vld ? r_rd_word : '0;
    assign w_slot_free = !r_out_vld || o_rsp.ready;

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.entry      = r_out_entry;
    assign o_rsp.needs_fill = r_out_fill;
    assign o_rsp.status     = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_dev        = r_dev;
        n_blk        = r_blk;
        n_now        = r_now;
        n_pick       = r_pick;
        n_addr       = r_addr;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_free       = r_free;
        n_lru_idx    = r_lru_idx;
        n_lru_time   = r_lru_time;
        n_res_entry  = r_res_entry;
        n_res_status = r_res_status;
        n_out_vld    = r_out_vld && !o_rsp.ready;
        n_out_entry  = r_out_entry;
        n_out_fill   = r_out_fill;
        n_out_status = r_out_status;
        w_rd_addr    = r_pick;
        w_wr_en      = 1'b0;
        w_wr_word    = w_rd_word;
        w_mod_status = ST_OK;
        w_mod_fill   = 1'b0;

        // Compare stage: first tag match wins; oldest free entry, ties to the lowest index.
        if (r_cmp_vld) begin
            if (!r_hit && w_rd_word.dev == r_dev && w_rd_word.blk == r_blk) begin
                n_hit     = 1'b1;
                n_hit_idx = r_cmp_idx;
            end
            if (w_rd_word.cnt == '0 && (!r_free || w_rd_word.stamp < r_lru_time)) begin
                n_free     = 1'b1;
                n_lru_idx  = r_cmp_idx;
                n_lru_time = w_rd_word.stamp;
            end
        end

        // Modify step for the entry read back at r_pick.
        case (r_op)
            OP_GET: begin
                if (r_hit) begin
                    if (w_rd_word.cnt == CNT_MAX) begin
                        w_mod_status = ST_OVERFLOW;
                    end else begin
                        w_wr_word.cnt = w_rd_word.cnt + 1'b1;
                    end
                    w_mod_fill = !w_rd_word.filled;
                end else begin
                    w_wr_word.dev = r_dev;
                    w_wr_word.blk = r_blk;
                    w_wr_word.cnt = CNT_W'(1);
                    w_mod_fill    = 1'b1;
                end
                w_wr_word.filled = 1'b1;
            end
            OP_PIN: begin
                if (w_rd_word.cnt == CNT_MAX) begin
                    w_mod_status = ST_OVERFLOW;
                end else begin
                    w_wr_word.cnt = w_rd_word.cnt + 1'b1;
                end
            end
            OP_RELEASE, OP_UNPIN: begin
                if (w_rd_word.cnt == '0) begin
                    w_mod_status = ST_UNDERFLOW;
                end else begin
                    w_wr_word.cnt = w_rd_word.cnt - 1'b1;
                    // stamp only when a release drops the last reference
                    if (r_op == OP_RELEASE && w_rd_word.cnt == CNT_W'(1)) begin
                        w_wr_word.stamp = r_now;
                    end
                end
            end
            default: begin
                w_mod_status = ST_OK;
            end
        endcase

        case (r_state)
            S_IDLE: begin
                w_rd_addr = IW'(i_req.entry_index);
                if (i_req.valid) begin
                    n_op  = t_op'(i_req.op);
                    n_dev = i_req.device;
                    n_blk = i_req.block_number;
                    n_now = i_req.now;
                    if (t_op'(i_req.op) == OP_GET) begin
                        n_addr  = '0;
                        n_hit   = 1'b0;
                        n_free  = 1'b0;
                        n_state = S_SCAN;
                    end else if (32'(i_req.entry_index) >= ENTRIES) begin
                        // out-of-range entry: ignore, report ok
                        n_res_entry  = i_req.entry_index;
                        n_res_status = ST_OK;
                        n_state      = S_RESP;
                    end else begin
                        n_pick  = IW'(i_req.entry_index);
                        n_state = S_MOD;
                    end
                end
            end
            S_SCAN: begin
                w_rd_addr = r_addr;
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_addr;
                if (r_addr == IW'(ENTRIES - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_DRAIN: begin
                n_cmp_vld = 1'b0;
                n_state   = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_hit) begin
                    n_pick    = r_hit_idx;
                    w_rd_addr = r_hit_idx;
                    n_state   = S_MOD;
                end else if (r_free) begin
                    n_pick    = r_lru_idx;
                    w_rd_addr = r_lru_idx;
                    n_state   = S_MOD;
                end else begin
                    n_res_entry  = '0;
                    n_res_status = ST_NO_FREE;
                    n_state      = S_RESP;
                end
            end
            S_MOD: begin
                // hold the read at r_pick until the output slot opens
                if (w_slot_free) begin
                    w_wr_en      = 1'b1;
                    n_out_vld    = 1'b1;
                    n_out_entry  = 5'(r_pick);
                    n_out_fill   = w_mod_fill;
                    n_out_status = w_mod_status;
                    n_state      = S_IDLE;
                end
            end
            S_RESP: begin
                if (w_slot_free) begin
                    n_out_vld    = 1'b1;
                    n_out_entry  = r_res_entry;
                    n_out_fill   = 1'b0;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_out_vld <= 1'b0;
            r_ent_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_hit     <= n_hit;
            r_free    <= n_free;
            r_out_vld <= n_out_vld;
            if (w_wr_en) begin
                r_ent_vld[r_pick] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_dev        <= n_dev;
        r_blk        <= n_blk;
        r_now        <= n_now;
        r_pick       <= n_pick;
        r_addr       <= n_addr;
        r_cmp_idx    <= n_cmp_idx;
        r_hit_idx    <= n_hit_idx;
        r_lru_idx    <= n_lru_idx;
        r_lru_time   <= n_lru_time;
        r_res_entry  <= n_res_entry;
        r_res_status <= n_res_status;
        r_out_entry  <= n_out_entry;
        r_out_fill   <= n_out_fill;
        r_out_status <= n_out_status;
    end

    // tag memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_pick] <= w_wr_word;
        end
        r_rd_word <= r_mem[w_rd_addr];
        r_rd_vld  <= r_ent_vld[w_rd_addr];
    end

`ifndef SYNTH
    // a miss must recycle an entry that holds no references
    a_miss_takes_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && r_op == OP_GET && !r_hit) |-> (w_rd_word.cnt == '0))
        else $error("miss recycled an entry with references");

    // a freshly loaded result always comes with a return to idle
    a_load_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> (r_state == S_IDLE))
        else $error("result loaded without finishing the item");

    // the sweep never addresses beyond the last entry
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (32'(r_addr) < ENTRIES))
        else $error("scan address out of range");
`endif

endmodule
